// ===== rtl/can_signal_extract_scale_unit_macros.svh =====
// assertion macros used by the checker file
`ifndef CAN_SIGNAL_EXTRACT_SCALE_UNIT_MACROS_SVH
`define CAN_SIGNAL_EXTRACT_SCALE_UNIT_MACROS_SVH

// same-cycle implication, off while reset is low
`define CSES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication after a fixed number of cycles
`define CSES_ASSERT_DLY(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

// ===== rtl/cses_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cses_pkg;

    localparam int PAYLOAD_BYTES_DEF = 8;
    localparam int ADDR_W            = 6;
    // edges from the accepting edge to the edge that takes the result
    localparam int LATENCY           = 6;

    // register indexes, the byte address is eight times the index
    localparam logic [2:0] REG_SIG_START  = 3'd0;
    localparam logic [2:0] REG_SIG_LENGTH = 3'd1;
    localparam logic [2:0] REG_SIG_LE     = 3'd2;
    localparam logic [2:0] REG_SIG_SIGNED = 3'd3;
    localparam logic [2:0] REG_FACTOR     = 3'd4;
    localparam logic [2:0] REG_OFFSET     = 3'd5;
    localparam logic [2:0] REG_MUX_FMT    = 3'd6;
    localparam logic [2:0] REG_MUX_MATCH  = 3'd7;

    typedef struct packed {
        logic [5:0]         sig_start_bit;
        logic [6:0]         sig_length;
        logic               sig_little_endian;
        logic               sig_signed;
        logic signed [31:0] scale_factor;
        logic signed [47:0] scale_offset;
        logic [15:0]        mux_format;
        logic signed [31:0] mux_match_value;
    } t_cfg;

    // per-beat side band carried along the scaling pipeline
    typedef struct packed {
        logic        valid;
        logic        present;
        logic        beyond;
        logic [63:0] raw;
    } t_meta;

endpackage
`default_nettype wire

// ===== rtl/cses_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cses_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cses_pkg::ADDR_W-1:0] paddr,
    input  wire logic [63:0]                 pwdata,
    output logic      [63:0]                 prdata,
    output logic                             pready,
    output cses_pkg::t_cfg                   o_cfg
);

    cses_pkg::t_cfg r_cfg;
    logic [2:0]     idx;
    logic           wr_en;

    assign idx    = paddr[5:3];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sig_start_bit     <= 6'd0;
            r_cfg.sig_length        <= 7'd8;
            r_cfg.sig_little_endian <= 1'b1;
            r_cfg.sig_signed        <= 1'b0;
            r_cfg.scale_factor      <= 32'sd65536;
            r_cfg.scale_offset      <= 48'sd0;
            r_cfg.mux_format        <= 16'd0;
            r_cfg.mux_match_value   <= 32'sd0;
        end else if (wr_en) begin
            case (idx)
                cses_pkg::REG_SIG_START:  r_cfg.sig_start_bit     <= pwdata[5:0];
                cses_pkg::REG_SIG_LENGTH: r_cfg.sig_length        <= pwdata[6:0];
                cses_pkg::REG_SIG_LE:     r_cfg.sig_little_endian <= pwdata[0];
                cses_pkg::REG_SIG_SIGNED: r_cfg.sig_signed        <= pwdata[0];
                cses_pkg::REG_FACTOR:     r_cfg.scale_factor      <= $signed(pwdata[31:0]);
                cses_pkg::REG_OFFSET:     r_cfg.scale_offset      <= $signed(pwdata[47:0]);
                cses_pkg::REG_MUX_FMT:    r_cfg.mux_format        <= pwdata[15:0];
                cses_pkg::REG_MUX_MATCH:  r_cfg.mux_match_value   <= $signed(pwdata[31:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            cses_pkg::REG_SIG_START:  prdata = {58'd0, r_cfg.sig_start_bit};
            cses_pkg::REG_SIG_LENGTH: prdata = {57'd0, r_cfg.sig_length};
            cses_pkg::REG_SIG_LE:     prdata = {63'd0, r_cfg.sig_little_endian};
            cses_pkg::REG_SIG_SIGNED: prdata = {63'd0, r_cfg.sig_signed};
            cses_pkg::REG_FACTOR:     prdata = {32'd0, r_cfg.scale_factor};
            cses_pkg::REG_OFFSET:     prdata = {16'd0, r_cfg.scale_offset};
            cses_pkg::REG_MUX_FMT:    prdata = {48'd0, r_cfg.mux_format};
            cses_pkg::REG_MUX_MATCH:  prdata = {32'd0, r_cfg.mux_match_value};
            default:                  prdata = 64'd0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/cses_extract.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cses_extract (
    input  wire logic [63:0] i_payload,
    input  wire logic [3:0]  i_nbytes,
    input  wire logic [5:0]  i_start_bit,
    input  wire logic [6:0]  i_len_field,
    input  wire logic        i_intel,
    input  wire logic        i_sgn,
    output logic      [63:0] o_raw,
    output logic             o_beyond
);

    logic [6:0]  len;
    logic [6:0]  seq;
    logic [6:0]  last;
    logic [5:0]  msb_idx;
    logic [63:0] mask;
    logic [63:0] be;
    logic [63:0] shifted;
    logic [63:0] v;

    always_comb begin
        // zero length acts as one, anything past 64 as 64
        if (i_len_field == 7'd0) begin
            len = 7'd1;
        end else if (i_len_field > 7'd64) begin
            len = 7'd64;
        end else begin
            len = i_len_field;
        end
        mask = {64{1'b1}} >> (7'd64 - len);
        msb_idx = 6'(len - 7'd1);
        be = {i_payload[7:0],   i_payload[15:8],  i_payload[23:16], i_payload[31:24],
              i_payload[39:32], i_payload[47:40], i_payload[55:48], i_payload[63:56]};
        // motorola start bit renumbered as a position in the byte-swapped word
        seq = {1'b0, i_start_bit[5:3], ~i_start_bit[2:0]};
        if (i_intel) begin
            last    = {1'b0, i_start_bit} + len - 7'd1;
            shifted = i_payload >> i_start_bit;
        end else begin
            last    = seq + len - 7'd1;
            shifted = be >> (6'd63 - last[5:0]);
        end
        o_beyond = (last[6:3] >= i_nbytes);
        v = shifted & mask;
        if (i_sgn && v[msb_idx]) begin
            v = v | ~mask;
        end
        o_raw = o_beyond ? 64'd0 : v;
    end

endmodule
`default_nettype wire

// ===== rtl/cses_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cses_scale (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  cses_pkg::t_meta         i_meta,
    input  wire logic               i_sgn,
    input  wire logic signed [31:0] i_factor,
    input  wire logic signed [47:0] i_offset,
    output cses_pkg::t_meta         o_meta,
    output logic             [63:0] o_scaled,
    output logic                    o_sat
);

    // magnitude stage
    cses_pkg::t_meta r_m2;
    logic            r_en2;
    logic            r_neg2;
    logic [63:0]     r_ua;
    logic [31:0]     r_uf;
    // partial products
    cses_pkg::t_meta r_m3;
    logic            r_en3;
    logic            r_neg3;
    logic [63:0]     r_p0;
    logic [63:0]     r_p1;
    // signed product
    cses_pkg::t_meta r_m4;
    logic            r_en4;
    logic [97:0]     r_sp;
    // result
    cses_pkg::t_meta r_m5;
    logic [63:0]     r_scaled;
    logic            r_sat;

    logic        rneg;
    logic        fneg;
    logic [31:0] fbits;
    logic [95:0] mag;
    logic [97:0] sum;
    logic        ovf;
    logic [63:0] n_scaled;
    logic        n_sat;

    assign rneg  = i_sgn && i_meta.raw[63];
    assign fbits = $unsigned(i_factor);
    assign fneg  = fbits[31];

    always_ff @(posedge i_clk) begin
        r_m2.present <= i_meta.present;
        r_m2.beyond  <= i_meta.beyond;
        r_m2.raw     <= i_meta.raw;
        r_en2        <= i_meta.present && !i_meta.beyond;
        r_neg2       <= rneg ^ fneg;
        r_ua         <= rneg ? (~i_meta.raw + 64'd1) : i_meta.raw;
        r_uf         <= fneg ? (~fbits + 32'd1) : fbits;

        r_m3.present <= r_m2.present;
        r_m3.beyond  <= r_m2.beyond;
        r_m3.raw     <= r_m2.raw;
        r_en3        <= r_en2;
        r_neg3       <= r_neg2;
        r_p0         <= r_ua[31:0] * r_uf;
        r_p1         <= r_ua[63:32] * r_uf;

        r_m4.present <= r_m3.present;
        r_m4.beyond  <= r_m3.beyond;
        r_m4.raw     <= r_m3.raw;
        r_en4        <= r_en3;
        r_sp         <= r_neg3 ? (~{2'b00, mag} + 98'd1) : {2'b00, mag};

        r_m5.present <= r_m4.present;
        r_m5.beyond  <= r_m4.beyond;
        r_m5.raw     <= r_m4.raw;
        r_scaled     <= n_scaled;
        r_sat        <= n_sat;

        if (!i_rst_n) begin
            r_m2.valid <= 1'b0;
            r_m3.valid <= 1'b0;
            r_m4.valid <= 1'b0;
            r_m5.valid <= 1'b0;
        end else begin
            r_m2.valid <= i_meta.valid;
            r_m3.valid <= r_m2.valid;
            r_m4.valid <= r_m3.valid;
            r_m5.valid <= r_m4.valid;
        end
    end

    always_comb begin
        mag = {32'd0, r_p0} + {r_p1, 32'd0};
        sum = r_sp + {{50{i_offset[47]}}, $unsigned(i_offset)};
        // fits in 64 bits only when the top bits are a pure sign extension
        ovf = !((&sum[97:63]) || (~|sum[97:63]));
        if (!r_en4) begin
            n_scaled = 64'd0;
            n_sat    = 1'b0;
        end else if (ovf) begin
            n_scaled = sum[97] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            n_sat    = 1'b1;
        end else begin
            n_scaled = sum[63:0];
            n_sat    = 1'b0;
        end
    end

    assign o_meta   = r_m5;
    assign o_scaled = r_scaled;
    assign o_sat    = r_sat;

endmodule
`default_nettype wire

// ===== rtl/can_signal_extract_scale_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// a frame taken by start is registered in r_v0 and r_payload, then in r_m1, then in
// the scale stages r_m2 to r_m5, which drive the result ports
// throughput: one frame per cycle, busy never rises; the 64 by 32 scaling product
// is split over two 32 by 32 multipliers in its own stage of the six-stage pipe
// reset clears the pipe valids and loads the register defaults; results cannot be stalled
module can_signal_extract_scale_unit #(
    parameter int P_PAYLOAD_BYTES = cses_pkg::PAYLOAD_BYTES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [63:0]                 i_payload,
    input  wire logic [3:0]                  i_payload_bytes,
    output logic                             o_valid,
    output logic                             o_present,
    output logic      [63:0]                 o_raw_bits,
    output logic signed [63:0]               o_scaled_value,
    output logic                             o_beyond_payload,
    output logic                             o_saturated,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cses_pkg::ADDR_W-1:0] paddr,
    input  wire logic [63:0]                 pwdata,
    output logic      [63:0]                 prdata,
    output logic                             pready
);

    localparam logic [3:0] MAX_BYTES = 4'(P_PAYLOAD_BYTES);

    cses_pkg::t_cfg  cfg;
    cses_pkg::t_meta r_m1;
    cses_pkg::t_meta n_m1;
    cses_pkg::t_meta m_out;

    logic        r_v0;
    logic [63:0] r_payload;
    logic [3:0]  r_nbytes;
    logic [3:0]  n_nbytes;
    logic        r_sgn1;

    logic [63:0] sig_raw;
    logic        sig_beyond;
    logic [63:0] mux_raw;
    logic        mux_beyond_unused;
    logic        mux_ok;
    logic [63:0] match_ext;
    logic [63:0] scaled;
    logic        sat;

    assign busy = 1'b0;

    cses_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign n_nbytes = (i_payload_bytes > MAX_BYTES) ? MAX_BYTES : i_payload_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_payload <= i_payload;
        r_nbytes  <= n_nbytes;
    end

    cses_extract u_sig (
        .i_payload   (r_payload),
        .i_nbytes    (r_nbytes),
        .i_start_bit (cfg.sig_start_bit),
        .i_len_field (cfg.sig_length),
        .i_intel     (cfg.sig_little_endian),
        .i_sgn       (cfg.sig_signed),
        .o_raw       (sig_raw),
        .o_beyond    (sig_beyond)
    );

    // a mux field past the payload reads as zero, which the extractor already gives
    cses_extract u_mux (
        .i_payload   (r_payload),
        .i_nbytes    (r_nbytes),
        .i_start_bit (cfg.mux_format[5:0]),
        .i_len_field (cfg.mux_format[12:6]),
        .i_intel     (cfg.mux_format[14]),
        .i_sgn       (cfg.mux_format[13]),
        .o_raw       (mux_raw),
        .o_beyond    (mux_beyond_unused)
    );

    always_comb begin
        match_ext = {{32{cfg.mux_match_value[31]}}, $unsigned(cfg.mux_match_value)};
        // an unsigned mux with bit 63 of its raw value set never matches
        mux_ok = !cfg.mux_format[15]
              || ((cfg.mux_format[13] || !mux_raw[63]) && (mux_raw == match_ext));
        n_m1.valid   = r_v0;
        n_m1.present = mux_ok;
        n_m1.beyond  = mux_ok && sig_beyond;
        n_m1.raw     = mux_ok ? sig_raw : 64'd0;
    end

    always_ff @(posedge i_clk) begin
        r_m1.present <= n_m1.present;
        r_m1.beyond  <= n_m1.beyond;
        r_m1.raw     <= n_m1.raw;
        r_sgn1       <= cfg.sig_signed;
        if (!i_rst_n) begin
            r_m1.valid <= 1'b0;
        end else begin
            r_m1.valid <= n_m1.valid;
        end
    end

    cses_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_meta   (r_m1),
        .i_sgn    (r_sgn1),
        .i_factor (cfg.scale_factor),
        .i_offset (cfg.scale_offset),
        .o_meta   (m_out),
        .o_scaled (scaled),
        .o_sat    (sat)
    );

    assign o_valid          = m_out.valid;
    assign o_present        = m_out.present;
    assign o_raw_bits       = m_out.raw;
    assign o_scaled_value   = $signed(scaled);
    assign o_beyond_payload = m_out.beyond;
    assign o_saturated      = sat;

endmodule
`default_nettype wire

// ===== rtl/cses_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "can_signal_extract_scale_unit_macros.svh"
module cses_chk (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic                        o_valid,
    input wire logic                        o_present,
    input wire logic [63:0]                 o_raw_bits,
    input wire logic signed [63:0]          o_scaled_value,
    input wire logic                        o_beyond_payload,
    input wire logic                        o_saturated
);

    localparam int LAT = cses_pkg::LATENCY;

    logic accepted;
    logic zero_out;
    logic at_rail;

    assign accepted = start && !busy;
    assign zero_out = (o_raw_bits == 64'd0) && (o_scaled_value == 64'sd0) && !o_saturated;
    assign at_rail  = (o_scaled_value == {1'b1, 63'd0})
                   || (o_scaled_value == {1'b0, {63{1'b1}}});

    `CSES_ASSERT_DLY(a_beat_out, i_clk, i_rst_n, accepted, LAT, o_valid, "beat lost in pipe")
    `CSES_ASSERT_IMP(a_beat_in, i_clk, i_rst_n, o_valid, $past(accepted, LAT), "result without beat")
    `CSES_ASSERT_IMP(a_absent, i_clk, i_rst_n, o_valid && !o_present, zero_out && !o_beyond_payload, "absent not zeroed")
    `CSES_ASSERT_IMP(a_beyond, i_clk, i_rst_n, o_valid && o_beyond_payload, o_present && zero_out, "beyond not zeroed")
    `CSES_ASSERT_IMP(a_sat, i_clk, i_rst_n, o_valid && o_saturated, at_rail, "saturation not at a rail")

endmodule

bind can_signal_extract_scale_unit cses_chk u_cses_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_present        (o_present),
    .o_raw_bits       (o_raw_bits),
    .o_scaled_value   (o_scaled_value),
    .o_beyond_payload (o_beyond_payload),
    .o_saturated      (o_saturated)
);
`default_nettype wire

// ===== tb/can_signal_extract_scale_unit_tb.sv =====
`timescale 1ns / 1ps

typedef struct packed {
    logic        present;
    logic [63:0] raw_bits;
    logic [63:0] scaled_value;
    logic        beyond_payload;
    logic        saturated;
} t_decode;

class signal_decode_board;
    cses_pkg::t_cfg cfg;
    t_decode        expected_decodes[$];
    int unsigned    mismatches;

    function new();
        cfg                   = '0;
        cfg.sig_length        = 7'd8;
        cfg.sig_little_endian = 1'b1;
        cfg.scale_factor      = 32'sd65536;
        mismatches            = 0;
    endfunction

    static function logic [63:0] low_bits(int unsigned w);
        return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    static function int unsigned reg_width(logic [2:0] idx);
        case (idx)
            cses_pkg::REG_SIG_START:  return 6;
            cses_pkg::REG_SIG_LENGTH: return 7;
            cses_pkg::REG_SIG_LE:     return 1;
            cses_pkg::REG_SIG_SIGNED: return 1;
            cses_pkg::REG_FACTOR:     return 32;
            cses_pkg::REG_OFFSET:     return 48;
            cses_pkg::REG_MUX_FMT:    return 16;
            default:                  return 32;
        endcase
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] value);
        case (idx)
            cses_pkg::REG_SIG_START:  cfg.sig_start_bit     = value[5:0];
            cses_pkg::REG_SIG_LENGTH: cfg.sig_length        = value[6:0];
            cses_pkg::REG_SIG_LE:     cfg.sig_little_endian = value[0];
            cses_pkg::REG_SIG_SIGNED: cfg.sig_signed        = value[0];
            cses_pkg::REG_FACTOR:     cfg.scale_factor      = value[31:0];
            cses_pkg::REG_OFFSET:     cfg.scale_offset      = value[47:0];
            cses_pkg::REG_MUX_FMT:    cfg.mux_format        = value[15:0];
            cses_pkg::REG_MUX_MATCH:  cfg.mux_match_value   = value[31:0];
            default: ;
        endcase
    endfunction

    // returns 1 when the field's highest-numbered byte is not in the frame
    function bit cut_field(logic [63:0] payload, int unsigned nbytes, int unsigned start,
                           int unsigned len_field, bit intel, bit sgn,
                           output logic [63:0] raw);
        int unsigned len;
        int unsigned seq;
        int unsigned top;
        logic [63:0] be;
        logic [63:0] v;
        len = (len_field == 0) ? 1 : ((len_field > 64) ? 64 : len_field);
        raw = '0;
        if (intel) begin
            top = start + len - 1;
            if (top / 8 >= nbytes) return 1'b1;
            v = (payload >> start) & low_bits(len);
        end else begin
            // motorola: walk the byte-swapped frame from the msb position
            seq = 8 * (start / 8) + 7 - start % 8;
            top = seq + len - 1;
            if (top / 8 >= nbytes) return 1'b1;
            be = {<<8{payload}};
            v  = (be >> (63 - top)) & low_bits(len);
        end
        if (sgn && len < 64 && v[len-1]) v = v | ~low_bits(len);
        raw = v;
        return 1'b0;
    endfunction

    function t_decode decode_frame(logic [63:0] payload, logic [3:0] nbytes_field);
        t_decode             d;
        int unsigned         nbytes;
        logic [63:0]         mux_raw;
        logic [63:0]         sig_raw;
        logic signed [127:0] wide_raw;
        logic signed [127:0] wide_factor;
        logic signed [127:0] wide_offset;
        logic signed [127:0] total;
        nbytes = (nbytes_field > cses_pkg::PAYLOAD_BYTES_DEF) ?
                 cses_pkg::PAYLOAD_BYTES_DEF : nbytes_field;
        d = '0;
        d.present = 1'b1;
        if (cfg.mux_format[15]) begin
            // a mux past the frame reads as zero
            void'(cut_field(payload, nbytes, cfg.mux_format[5:0], cfg.mux_format[12:6],
                            cfg.mux_format[14], cfg.mux_format[13], mux_raw));
            if (!cfg.mux_format[13] && mux_raw[63])
                d.present = 1'b0;
            else if (mux_raw != {{32{cfg.mux_match_value[31]}}, cfg.mux_match_value})
                d.present = 1'b0;
        end
        if (d.present) begin
            d.beyond_payload = cut_field(payload, nbytes, cfg.sig_start_bit, cfg.sig_length,
                                         cfg.sig_little_endian, cfg.sig_signed, sig_raw);
            if (!d.beyond_payload) begin
                d.raw_bits  = sig_raw;
                wide_raw    = cfg.sig_signed ? {{64{sig_raw[63]}}, sig_raw} : {64'd0, sig_raw};
                wide_factor = {{96{cfg.scale_factor[31]}}, cfg.scale_factor};
                wide_offset = {{80{cfg.scale_offset[47]}}, cfg.scale_offset};
                total       = wide_raw * wide_factor + wide_offset;
                if (total[127:63] == '0 || total[127:63] == '1) begin
                    d.scaled_value = total[63:0];
                end else begin
                    d.saturated    = 1'b1;
                    d.scaled_value = total[127] ? 64'h8000_0000_0000_0000
                                                : 64'h7fff_ffff_ffff_ffff;
                end
            end
        end
        return d;
    endfunction

    function void note_frame(logic [63:0] payload, logic [3:0] nbytes);
        t_decode d;
        d = decode_frame(payload, nbytes);
        expected_decodes.insert(expected_decodes.size(), d);
    endfunction

    function void check_result(t_decode got);
        t_decode want;
        if (expected_decodes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: decode result with no frame outstanding", $realtime);
            return;
        end
        want = expected_decodes.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: decode mismatch", $realtime);
                $display("  exp present=%b raw=%h scaled=%h beyond=%b sat=%b",
                         want.present, want.raw_bits, want.scaled_value,
                         want.beyond_payload, want.saturated);
                $display("  got present=%b raw=%h scaled=%h beyond=%b sat=%b",
                         got.present, got.raw_bits, got.scaled_value,
                         got.beyond_payload, got.saturated);
            end
        end
    endfunction

    function int unsigned pending();
        return expected_decodes.size();
    endfunction
endclass

module can_signal_extract_scale_unit_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int FRAME_TARGET   = 1700;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [63:0]                 i_payload;
    logic [3:0]                  i_payload_bytes;
    logic                        o_valid;
    logic                        o_present;
    logic [63:0]                 o_raw_bits;
    logic signed [63:0]          o_scaled_value;
    logic                        o_beyond_payload;
    logic                        o_saturated;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [cses_pkg::ADDR_W-1:0] paddr;
    logic [63:0]                 pwdata;
    logic [63:0]                 prdata;
    logic                        pready;

    signal_decode_board board = new();
    int unsigned        frames_sent = 0;
    int unsigned        idle_cycles = 0;

    can_signal_extract_scale_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_payload       (i_payload),
        .i_payload_bytes (i_payload_bytes),
        .o_valid         (o_valid),
        .o_present       (o_present),
        .o_raw_bits      (o_raw_bits),
        .o_scaled_value  (o_scaled_value),
        .o_beyond_payload(o_beyond_payload),
        .o_saturated     (o_saturated),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) board.note_frame(i_payload, i_payload_bytes);
            if (o_valid)
                board.check_result({o_present, o_raw_bits, o_scaled_value,
                                    o_beyond_payload, o_saturated});
            if ((start && !busy) || o_valid) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    function automatic int unsigned seq_to_start(int unsigned seq);
        return 8 * (seq / 8) + 7 - seq % 8;
    endfunction

    // writes a field into the frame so that the mux sees the wanted value
    function automatic logic [63:0] place_field(logic [63:0] payload, int unsigned start,
                                                int unsigned len_field, bit intel,
                                                logic [63:0] value);
        int unsigned len;
        int          last;
        int          pos;
        logic [63:0] be;
        len = (len_field == 0) ? 1 : ((len_field > 64) ? 64 : len_field);
        if (intel) begin
            for (int b = 0; b < len; b++)
                if (start + b < 64) payload[start + b] = value[b];
            return payload;
        end
        be   = {<<8{payload}};
        last = seq_to_start(start) + len - 1;
        for (int b = 0; b < len; b++) begin
            pos = 63 - last + b;
            if (pos >= 0 && pos < 64) be[pos] = value[b];
        end
        return {<<8{be}};
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        logic [63:0] mask;
        logic [63:0] data;
        mask = board.low_bits(board.reg_width(idx));
        data = value;
        // unused upper bits sometimes carry junk
        if ($urandom_range(0, 1)) data = ({$urandom, $urandom} & ~mask) | (value & mask);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.write_reg(idx, data);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(logic [5:0] sig_start, logic [6:0] sig_len, bit le, bit sgn,
                              logic [31:0] factor, logic [47:0] offset,
                              logic [15:0] mux_fmt, logic [31:0] match);
        @(negedge i_clk);
        start <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (cses_pkg::LATENCY) @(posedge i_clk);
        write_reg(cses_pkg::REG_SIG_START, 64'(sig_start));
        write_reg(cses_pkg::REG_SIG_LENGTH, 64'(sig_len));
        write_reg(cses_pkg::REG_SIG_LE, 64'(le));
        write_reg(cses_pkg::REG_SIG_SIGNED, 64'(sgn));
        write_reg(cses_pkg::REG_FACTOR, 64'(factor));
        write_reg(cses_pkg::REG_OFFSET, 64'(offset));
        write_reg(cses_pkg::REG_MUX_FMT, 64'(mux_fmt));
        write_reg(cses_pkg::REG_MUX_MATCH, 64'(match));
    endtask

    task automatic send_frame(logic [63:0] payload, logic [3:0] nbytes, int unsigned gap);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start           <= 1'b1;
        i_payload       <= payload;
        i_payload_bytes <= nbytes;
        do @(posedge i_clk); while (busy);
        frames_sent++;
    endtask

    task automatic random_phase(int unsigned n_frames);
        int unsigned sig_len;
        int unsigned sig_eff;
        int unsigned sig_start;
        int unsigned mux_len;
        int unsigned mux_eff;
        int unsigned mux_start;
        int unsigned s;
        bit          sig_le;
        bit          sig_sgn;
        bit          mux_en;
        bit          mux_le;
        bit          mux_sgn;
        bit          burst;
        logic [31:0] factor;
        logic [47:0] offset;
        logic [31:0] match;
        logic [63:0] bits;
        logic [63:0] payload;
        logic [3:0]  nbytes;
        case ($urandom_range(0, 7))
            0:       sig_len = 0;
            1:       sig_len = 64;
            2:       sig_len = $urandom_range(65, 127);
            3:       sig_len = 1;
            4, 5:    sig_len = $urandom_range(1, 16);
            default: sig_len = $urandom_range(1, 64);
        endcase
        sig_eff = (sig_len == 0) ? 1 : ((sig_len > 64) ? 64 : sig_len);
        sig_le  = $urandom_range(0, 1);
        sig_sgn = $urandom_range(0, 1);
        if ($urandom_range(0, 3) != 0) begin
            s = $urandom_range(0, 64 - sig_eff);
            sig_start = sig_le ? s : seq_to_start(s);
        end else begin
            sig_start = $urandom_range(0, 63);
        end
        case ($urandom_range(0, 7))
            0:       factor = 32'h8000_0000;
            1:       factor = 32'h7fff_ffff;
            2:       factor = 32'h0001_0000;
            3:       factor = 32'h0000_0000;
            4:       factor = $urandom_range(0, 1 << 20);
            default: factor = $urandom;
        endcase
        case ($urandom_range(0, 5))
            0:       offset = 48'h8000_0000_0000;
            1:       offset = 48'h7fff_ffff_ffff;
            2:       offset = 48'h0;
            default: offset = {$urandom, $urandom};
        endcase
        mux_en = $urandom_range(0, 1);
        case ($urandom_range(0, 9))
            0:       mux_len = $urandom_range(0, 127);
            1:       mux_len = 64;
            default: mux_len = $urandom_range(1, 8);
        endcase
        mux_eff = (mux_len == 0) ? 1 : ((mux_len > 64) ? 64 : mux_len);
        mux_le  = $urandom_range(0, 1);
        mux_sgn = $urandom_range(0, 1);
        if ($urandom_range(0, 3) != 0) begin
            s = $urandom_range(0, 64 - mux_eff);
            mux_start = mux_le ? s : seq_to_start(s);
        end else begin
            mux_start = $urandom_range(0, 63);
        end
        bits = {$urandom, $urandom} << (64 - mux_eff);
        if (mux_sgn)
            bits = $signed(bits) >>> (64 - mux_eff);
        else
            bits = bits >> (64 - mux_eff);
        case ($urandom_range(0, 15))
            0:       match = 32'h8000_0000;
            1:       match = 32'h7fff_ffff;
            2:       match = $urandom;
            default: match = bits[31:0];
        endcase
        set_config(6'(sig_start), 7'(sig_len), sig_le, sig_sgn, factor, offset,
                   {mux_en, mux_le, mux_sgn, 7'(mux_len), 6'(mux_start)}, match);
        burst = ($urandom_range(0, 3) == 0);
        repeat (n_frames) begin
            case ($urandom_range(0, 19))
                0:       payload = '0;
                1:       payload = '1;
                default: payload = {$urandom, $urandom};
            endcase
            nbytes = ($urandom_range(0, 4) != 0) ? 4'd8 : 4'($urandom_range(0, 15));
            // mostly frames whose mux selects the signal
            if (mux_en && $urandom_range(0, 3) != 0)
                payload = place_field(payload, mux_start, mux_len, mux_le,
                                      {{32{match[31]}}, match});
            send_frame(payload, nbytes, burst ? 0 : $urandom_range(0, 10));
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_payload       = '0;
        i_payload_bytes = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults straight out of reset, including empty and oversized frames
        send_frame('0, 4'd0, $urandom_range(0, 10));
        send_frame('1, 4'd8, $urandom_range(0, 10));
        send_frame(64'h0123_4567_89ab_cdef, 4'd15, $urandom_range(0, 10));

        // full-width signed signal, largest factor and offset
        set_config(6'd0, 7'd64, 1'b1, 1'b1, 32'h7fff_ffff, 48'h7fff_ffff_ffff, 16'h0, 32'h0);
        send_frame('1, 4'd8, $urandom_range(0, 10));
        send_frame(64'h8000_0000_0000_0000, 4'd8, $urandom_range(0, 10));
        send_frame({$urandom, $urandom}, 4'd7, $urandom_range(0, 10));

        // full-width unsigned signal, most negative factor and offset
        set_config(6'd0, 7'd64, 1'b1, 1'b0, 32'h8000_0000, 48'h8000_0000_0000, 16'h0,
                   32'h0);
        send_frame('1, 4'd8, $urandom_range(0, 10));
        send_frame(64'h1, 4'd8, $urandom_range(0, 10));

        // motorola across the whole frame, clamps high
        set_config(6'd7, 7'd64, 1'b0, 1'b0, 32'h7fff_ffff, 48'h7fff_ffff_ffff, 16'h0,
                   32'h7fff_ffff);
        send_frame('1, 4'd8, $urandom_range(0, 10));
        send_frame({$urandom, $urandom}, 4'd8, $urandom_range(0, 10));

        // zero length acts as one bit, motorola on the top bit
        set_config(6'd63, 7'd0, 1'b0, 1'b1, 32'h0001_0000, 48'h0, 16'h0, 32'h0);
        send_frame(64'h8000_0000_0000_0000, 4'd8, $urandom_range(0, 10));
        send_frame(64'h7fff_ffff_ffff_ffff, 4'd8, $urandom_range(0, 10));

        // oversized length, motorola lsb lands past byte 7
        set_config(6'd56, 7'd127, 1'b0, 1'b0, 32'h0001_0000, 48'h0, 16'h0, 32'h0);
        send_frame('1, 4'd8, $urandom_range(0, 10));

        // byte mux: match, mismatch, mux past the frame
        set_config(6'd8, 7'd16, 1'b1, 1'b1, 32'h0003_0000, 48'hffff_fffb_0000,
                   {1'b1, 1'b1, 1'b0, 7'd8, 6'd0}, 32'h0000_005a);
        send_frame(64'h0000_0000_00c3_805a, 4'd8, $urandom_range(0, 10));
        send_frame(64'h0000_0000_00c3_8011, 4'd8, $urandom_range(0, 10));
        send_frame(64'h0000_0000_00c3_805a, 4'd0, $urandom_range(0, 10));

        // unsigned 64-bit mux with its top bit set never matches
        set_config(6'd0, 7'd12, 1'b0, 1'b0, 32'h0000_8000, 48'h1,
                   {1'b1, 1'b1, 1'b0, 7'd64, 6'd0}, 32'h8000_0000);
        send_frame('1, 4'd8, $urandom_range(0, 10));
        send_frame({$urandom, $urandom}, 4'd0, $urandom_range(0, 10));

        // every mux format bit set: mux always past the frame, reads zero
        set_config(6'd5, 7'd33, 1'b1, 1'b1, 32'h0001_0000, 48'h0, 16'hffff, 32'h0);
        send_frame({$urandom, $urandom}, 4'd8, $urandom_range(0, 10));
        send_frame({$urandom, $urandom}, 4'd3, $urandom_range(0, 10));

        while (frames_sent < FRAME_TARGET)
            random_phase($urandom_range(20, 80));

        @(negedge i_clk);
        start <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (cses_pkg::LATENCY + 4) @(posedge i_clk);

        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
